### sv/lpcp_pkg.sv
// ----------------------------------------------------------------------------
// lpcp_pkg
// Shared widths, types and arithmetic helpers for the line pair closest
// points pipeline.
// ----------------------------------------------------------------------------
package lpcp_pkg;

	localparam int FRACTION_BITS = 16;

	localparam int IN_W     = 32;                    // port coordinate / slope
	localparam int D_W      = IN_W + 1;              // point and slope differences
	localparam int N_W      = 2 * IN_W + 1;          // normal n = d1 x d2
	localparam int C_W      = 2 * IN_W + 2;          // w x d
	localparam int CP_W     = C_W - 1;               // w component * slope
	localparam int LIMB_W   = 32;
	localparam int PART_W   = C_W - LIMB_W + 1;      // signed split operand
	localparam int PP_W     = 2 * PART_W;            // partial product
	localparam int PROD_W   = 2 * C_W;               // dot product term
	localparam int DEN_W    = 130;                   // n.n, never negative
	localparam int NUM_W    = PROD_W;                // (w x d).n
	localparam int LB_W     = NUM_W - 3 * LIMB_W + 1;// numerator limb, signed
	localparam int MP_W     = LB_W + IN_W;           // limb * slope
	localparam int P_W      = NUM_W + IN_W;          // direction * numerator
	localparam int Q_W      = 34;                    // quotient bits kept
	localparam int R_W      = P_W + 1;               // divider remainder
	localparam int SUM_W    = Q_W + 3;               // point + rounded quotient
	localparam int DIV_LAT  = Q_W + 4;               // divider stages
	localparam int PIPE_LAT = 8 + DIV_LAT;           // start to done

	localparam logic signed [IN_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [IN_W-1:0] SAT_MIN = -32'sh7FFF_FFFF - 32'sh1;

	typedef struct packed {
		logic valid;
		logic zero;     // parallel lines: force a zero result
	} div_ctl_t;

	// sel 0: low limb as unsigned value, sel 1: signed upper part
	function automatic logic signed [PART_W-1:0] part(input logic signed [C_W-1:0] x,
			input logic sel);
		logic signed [PART_W-1:0] r;
		if (sel) begin
			r = PART_W'(x >>> LIMB_W);
		end else begin
			r = $signed({{(PART_W-LIMB_W){1'b0}}, x[LIMB_W-1:0]});
		end
		return r;
	endfunction

	// order: lo*lo, lo*hi, hi*lo, hi*hi
	function automatic logic signed [PROD_W-1:0] pp_sum(input logic signed [PP_W-1:0] p0,
			input logic signed [PP_W-1:0] p1, input logic signed [PP_W-1:0] p2,
			input logic signed [PP_W-1:0] p3);
		return PROD_W'(p0) + (PROD_W'(p1) <<< LIMB_W) + (PROD_W'(p2) <<< LIMB_W)
			+ (PROD_W'(p3) <<< (2 * LIMB_W));
	endfunction

	function automatic logic signed [LB_W-1:0] limb(input logic signed [NUM_W-1:0] x,
			input logic [1:0] l);
		logic signed [LB_W-1:0] r;
		case (l)
			2'd0: r = $signed({{(LB_W-LIMB_W){1'b0}}, x[LIMB_W-1:0]});
			2'd1: r = $signed({{(LB_W-LIMB_W){1'b0}}, x[2*LIMB_W-1:LIMB_W]});
			2'd2: r = $signed({{(LB_W-LIMB_W){1'b0}}, x[3*LIMB_W-1:2*LIMB_W]});
			2'd3: r = LB_W'(x >>> (3 * LIMB_W));
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [P_W-1:0] limb_sum(input logic signed [MP_W-1:0] m0,
			input logic signed [MP_W-1:0] m1, input logic signed [MP_W-1:0] m2,
			input logic signed [MP_W-1:0] m3);
		return P_W'(m0) + (P_W'(m1) <<< LIMB_W) + (P_W'(m2) <<< (2 * LIMB_W))
			+ (P_W'(m3) <<< (3 * LIMB_W));
	endfunction

endpackage

### sv/lpcp_div.sv
// ----------------------------------------------------------------------------
// lpcp_div
// Pipelined divider: point + round(num/den), saturated to 32 bits, or zero.
// ----------------------------------------------------------------------------
module lpcp_div import lpcp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  div_ctl_t                  ctl_i,
	input  logic signed [P_W-1:0]     num_i,
	input  logic        [DEN_W-1:0]   den_i,
	input  logic signed [IN_W-1:0]    pnt_i,
	output div_ctl_t                  ctl_o,
	output logic signed [IN_W-1:0]    res_o
);

	// stage A: magnitude and sign
	div_ctl_t                  ctl_sa;
	logic        [P_W-1:0]     mag_sa;
	logic                      neg_sa;
	logic        [DEN_W-1:0]   den_sa;
	logic signed [IN_W-1:0]    pnt_sa;

	// stage B and one stage per quotient bit
	div_ctl_t                  ctl_s [0:Q_W];
	logic        [R_W-1:0]     rem_s [0:Q_W];
	logic        [Q_W-1:0]     quo_s [0:Q_W];
	logic        [DEN_W-1:0]   den_s [0:Q_W];
	logic signed [IN_W-1:0]    pnt_s [0:Q_W];
	logic                      neg_s [0:Q_W];
	logic                      ovf_s [0:Q_W];

	// stage C: rounding
	div_ctl_t                  ctl_sc;
	logic        [Q_W:0]       quo_sc;
	logic signed [IN_W-1:0]    pnt_sc;
	logic                      neg_sc;
	logic                      ovf_sc;

	logic signed [SUM_W-1:0]   qv;
	logic signed [SUM_W-1:0]   sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_sa <= '0;
			ctl_sc <= '0;
			ctl_o  <= '0;
			for (int i = 0; i <= Q_W; i++) begin
				ctl_s[i] <= '0;
			end
		end else begin
			ctl_sa   <= ctl_i;
			ctl_s[0] <= ctl_sa;
			for (int i = 0; i < Q_W; i++) begin
				ctl_s[i+1] <= ctl_s[i];
			end
			ctl_sc <= ctl_s[Q_W];
			ctl_o  <= ctl_sc;
		end
	end

	always_ff @(posedge clk) begin
		neg_sa <= num_i[P_W-1];
		mag_sa <= num_i[P_W-1] ? P_W'(-num_i) : P_W'(num_i);
		den_sa <= den_i;
		pnt_sa <= pnt_i;

		// a quotient of 2^Q_W or more saturates whatever the point
		ovf_s[0] <= R_W'(mag_sa) >= (R_W'(den_sa) << Q_W);
		rem_s[0] <= R_W'(mag_sa);
		quo_s[0] <= '0;
		den_s[0] <= den_sa;
		pnt_s[0] <= pnt_sa;
		neg_s[0] <= neg_sa;
	end

	for (genvar i = 0; i < Q_W; i++) begin : g_step
		localparam int B = Q_W - 1 - i;
		logic [R_W-1:0] dsh;
		logic           ge;
		assign dsh = R_W'(den_s[i]) << B;
		assign ge  = rem_s[i] >= dsh;
		always_ff @(posedge clk) begin
			rem_s[i+1] <= ge ? rem_s[i] - dsh : rem_s[i];
			quo_s[i+1] <= quo_s[i] | (Q_W'(ge) << B);
			den_s[i+1] <= den_s[i];
			pnt_s[i+1] <= pnt_s[i];
			neg_s[i+1] <= neg_s[i];
			ovf_s[i+1] <= ovf_s[i];
		end
	end

	// ties round away from zero: magnitude rounds up when 2*rem >= den
	always_ff @(posedge clk) begin
		quo_sc <= (Q_W+1)'(quo_s[Q_W])
			+ (Q_W+1)'((rem_s[Q_W] << 1) >= R_W'(den_s[Q_W]));
		pnt_sc <= pnt_s[Q_W];
		neg_sc <= neg_s[Q_W];
		ovf_sc <= ovf_s[Q_W];
	end

	always_comb begin
		qv  = neg_sc ? -$signed(SUM_W'(quo_sc)) : $signed(SUM_W'(quo_sc));
		sum = SUM_W'(pnt_sc) + qv;
	end

	always_ff @(posedge clk) begin
		if (ctl_sc.zero) begin
			res_o <= '0;
		end else if (ovf_sc) begin
			res_o <= neg_sc ? SAT_MIN : SAT_MAX;
		end else if (sum > SUM_W'(SAT_MAX)) begin
			res_o <= SAT_MAX;
		end else if (sum < SUM_W'(SAT_MIN)) begin
			res_o <= SAT_MIN;
		end else begin
			res_o <= sum[IN_W-1:0];
		end
	end

endmodule

### sv/line_pair_closest_points.sv
// ----------------------------------------------------------------------------
// line_pair_closest_points
// Closest points between two 3D lines given as point plus dx/dz, dy/dz slopes.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle; busy never rises, nothing stalls.
// Depth is set by the divider, one remainder compare-subtract per quotient bit.
// Reset: arst_n clears all valid bits at once; data registers keep no reset.
// Results go out as a one-cycle done strobe; the receiver cannot stall.
module line_pair_closest_points import lpcp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic signed [IN_W-1:0] first_point_x,
	input  logic signed [IN_W-1:0] first_point_y,
	input  logic signed [IN_W-1:0] first_point_z,
	input  logic signed [IN_W-1:0] second_point_x,
	input  logic signed [IN_W-1:0] second_point_y,
	input  logic signed [IN_W-1:0] second_point_z,
	input  logic signed [IN_W-1:0] first_slope_x,
	input  logic signed [IN_W-1:0] first_slope_y,
	input  logic signed [IN_W-1:0] second_slope_x,
	input  logic signed [IN_W-1:0] second_slope_y,
	output logic                   done,
	output logic signed [IN_W-1:0] near_first_x,
	output logic signed [IN_W-1:0] near_first_y,
	output logic signed [IN_W-1:0] near_first_z,
	output logic signed [IN_W-1:0] near_second_x,
	output logic signed [IN_W-1:0] near_second_y,
	output logic signed [IN_W-1:0] near_second_z,
	output logic                   parallel_fail
);

	// Method: n = d1 x d2, w = p2 - p1, den = n.n,
	// num_s = (w x d2).n, num_t = (w x d1).n, with d = (slope_x, slope_y, 1.0).
	// near_first[k] = p1[k] + round(d1[k]*num_s/den), likewise for line two.
	// Stages 1-8 build the six products and den; each of six dividers then
	// handles one coordinate. All wide multiplies are split into ~32-bit parts.

	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// valid and parallel flags, one per stage
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic fail_s1, fail_s2, fail_s3, fail_s4, fail_s5, fail_s6, fail_s7, fail_s8;

	// points ride along to the dividers: p1 x,y,z then p2 x,y,z
	logic signed [IN_W-1:0] pnt_s1 [6];
	logic signed [IN_W-1:0] pnt_s2 [6];
	logic signed [IN_W-1:0] pnt_s3 [6];
	logic signed [IN_W-1:0] pnt_s4 [6];
	logic signed [IN_W-1:0] pnt_s5 [6];
	logic signed [IN_W-1:0] pnt_s6 [6];
	logic signed [IN_W-1:0] pnt_s7 [6];
	logic signed [IN_W-1:0] pnt_s8 [6];

	// slopes: a1, b1, a2, b2
	logic signed [IN_W-1:0] sl_s1 [4];
	logic signed [IN_W-1:0] sl_s2 [4];
	logic signed [IN_W-1:0] sl_s3 [4];
	logic signed [IN_W-1:0] sl_s4 [4];
	logic signed [IN_W-1:0] sl_s5 [4];
	logic signed [IN_W-1:0] sl_s6 [4];

	logic signed [D_W-1:0]    w_s1 [3];
	logic signed [D_W-1:0]    w_s2 [3];
	logic signed [D_W-1:0]    sdx_s1, sdy_s1;
	logic signed [2*IN_W-1:0] m1_s1, m2_s1;

	logic signed [N_W-1:0]    n_s2 [3];
	logic signed [N_W-1:0]    n_s3 [3];
	logic signed [CP_W-1:0]   crs_s2 [4];
	logic signed [CP_W-1:0]   crt_s2 [4];

	logic signed [C_W-1:0]    cs_s3 [3];
	logic signed [C_W-1:0]    ct_s3 [3];

	logic signed [PP_W-1:0]   dpp_s4 [3][4];
	logic signed [PP_W-1:0]   spp_s4 [3][4];
	logic signed [PP_W-1:0]   tpp_s4 [3][4];

	logic signed [PROD_W-1:0] dpr_s5 [3];
	logic signed [PROD_W-1:0] spr_s5 [3];
	logic signed [PROD_W-1:0] tpr_s5 [3];

	logic        [DEN_W-1:0]  den_s6, den_s7, den_s8;
	logic signed [NUM_W-1:0]  nums_s6, numt_s6, nums_s7, numt_s7;
	logic signed [PROD_W-1:0] dsum, ssum, tsum;

	// d*num partials: s*a1, s*b1, t*a2, t*b2, four limbs each
	logic signed [MP_W-1:0]   mpp_s7 [4][4];
	logic signed [P_W-1:0]    prod_s8 [6];

	div_ctl_t                 dctl_in;
	div_ctl_t                 dctl [6];
	logic signed [IN_W-1:0]   res  [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <= '0;
			{fail_s1, fail_s2, fail_s3, fail_s4, fail_s5, fail_s6, fail_s7, fail_s8} <= '0;
		end else begin
			{v_s8, v_s7, v_s6, v_s5, v_s4, v_s3, v_s2, v_s1} <=
				{v_s7, v_s6, v_s5, v_s4, v_s3, v_s2, v_s1, accept};
			// parallel exactly when both slope pairs match
			{fail_s8, fail_s7, fail_s6, fail_s5, fail_s4, fail_s3, fail_s2, fail_s1} <=
				{fail_s7, fail_s6, fail_s5, fail_s4, fail_s3, fail_s2, fail_s1,
				first_slope_x == second_slope_x && first_slope_y == second_slope_y};
		end
	end

	// stage 1: differences and the two z-normal products
	always_ff @(posedge clk) begin
		pnt_s1 <= '{first_point_x, first_point_y, first_point_z,
			second_point_x, second_point_y, second_point_z};
		sl_s1  <= '{first_slope_x, first_slope_y, second_slope_x, second_slope_y};
		w_s1[0] <= D_W'(second_point_x) - D_W'(first_point_x);
		w_s1[1] <= D_W'(second_point_y) - D_W'(first_point_y);
		w_s1[2] <= D_W'(second_point_z) - D_W'(first_point_z);
		sdx_s1  <= D_W'(second_slope_x) - D_W'(first_slope_x);
		sdy_s1  <= D_W'(first_slope_y) - D_W'(second_slope_y);
		m1_s1   <= first_slope_x * second_slope_y;
		m2_s1   <= first_slope_y * second_slope_x;
	end

	// stage 2: normal vector, slope products for both cross products
	always_ff @(posedge clk) begin
		pnt_s2 <= pnt_s1;
		sl_s2  <= sl_s1;
		w_s2   <= w_s1;
		n_s2[0] <= N_W'(sdy_s1) <<< FRACTION_BITS;
		n_s2[1] <= N_W'(sdx_s1) <<< FRACTION_BITS;
		n_s2[2] <= N_W'(m1_s1) - N_W'(m2_s1);
		// w x d2 terms
		crs_s2[0] <= w_s1[2] * sl_s1[3];
		crs_s2[1] <= w_s1[2] * sl_s1[2];
		crs_s2[2] <= w_s1[0] * sl_s1[3];
		crs_s2[3] <= w_s1[1] * sl_s1[2];
		// w x d1 terms
		crt_s2[0] <= w_s1[2] * sl_s1[1];
		crt_s2[1] <= w_s1[2] * sl_s1[0];
		crt_s2[2] <= w_s1[0] * sl_s1[1];
		crt_s2[3] <= w_s1[1] * sl_s1[0];
	end

	// stage 3: finish both cross products (z component of d is one unit)
	always_ff @(posedge clk) begin
		pnt_s3 <= pnt_s2;
		sl_s3  <= sl_s2;
		n_s3   <= n_s2;
		cs_s3[0] <= (C_W'(w_s2[1]) <<< FRACTION_BITS) - C_W'(crs_s2[0]);
		cs_s3[1] <= C_W'(crs_s2[1]) - (C_W'(w_s2[0]) <<< FRACTION_BITS);
		cs_s3[2] <= C_W'(crs_s2[2]) - C_W'(crs_s2[3]);
		ct_s3[0] <= (C_W'(w_s2[1]) <<< FRACTION_BITS) - C_W'(crt_s2[0]);
		ct_s3[1] <= C_W'(crt_s2[1]) - (C_W'(w_s2[0]) <<< FRACTION_BITS);
		ct_s3[2] <= C_W'(crt_s2[2]) - C_W'(crt_s2[3]);
	end

	// stage 4: split products for n.n, cs.n, ct.n
	always_ff @(posedge clk) begin
		pnt_s4 <= pnt_s3;
		sl_s4  <= sl_s3;
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 4; j++) begin
				dpp_s4[k][j] <= part(C_W'(n_s3[k]), j[1]) * part(C_W'(n_s3[k]), j[0]);
				spp_s4[k][j] <= part(cs_s3[k], j[1]) * part(C_W'(n_s3[k]), j[0]);
				tpp_s4[k][j] <= part(ct_s3[k], j[1]) * part(C_W'(n_s3[k]), j[0]);
			end
		end
	end

	// stage 5: reassemble the nine products
	always_ff @(posedge clk) begin
		pnt_s5 <= pnt_s4;
		sl_s5  <= sl_s4;
		for (int k = 0; k < 3; k++) begin
			dpr_s5[k] <= pp_sum(dpp_s4[k][0], dpp_s4[k][1], dpp_s4[k][2], dpp_s4[k][3]);
			spr_s5[k] <= pp_sum(spp_s4[k][0], spp_s4[k][1], spp_s4[k][2], spp_s4[k][3]);
			tpr_s5[k] <= pp_sum(tpp_s4[k][0], tpp_s4[k][1], tpp_s4[k][2], tpp_s4[k][3]);
		end
	end

	// stage 6: dot sums
	always_comb begin
		dsum = dpr_s5[0] + dpr_s5[1] + dpr_s5[2];
		ssum = spr_s5[0] + spr_s5[1] + spr_s5[2];
		tsum = tpr_s5[0] + tpr_s5[1] + tpr_s5[2];
	end

	always_ff @(posedge clk) begin
		pnt_s6  <= pnt_s5;
		sl_s6   <= sl_s5;
		den_s6  <= dsum[DEN_W-1:0];
		nums_s6 <= ssum;
		numt_s6 <= tsum;
	end

	// stage 7: numerator limbs times slopes
	always_ff @(posedge clk) begin
		pnt_s7  <= pnt_s6;
		den_s7  <= den_s6;
		nums_s7 <= nums_s6;
		numt_s7 <= numt_s6;
		for (int d = 0; d < 4; d++) begin
			for (int l = 0; l < 4; l++) begin
				mpp_s7[d][l] <= limb((d < 2) ? nums_s6 : numt_s6, 2'(l)) * sl_s6[d];
			end
		end
	end

	// stage 8: six dividends; z uses the unit direction, a plain shift
	always_ff @(posedge clk) begin
		pnt_s8     <= pnt_s7;
		den_s8     <= den_s7;
		prod_s8[0] <= limb_sum(mpp_s7[0][0], mpp_s7[0][1], mpp_s7[0][2], mpp_s7[0][3]);
		prod_s8[1] <= limb_sum(mpp_s7[1][0], mpp_s7[1][1], mpp_s7[1][2], mpp_s7[1][3]);
		prod_s8[2] <= P_W'(nums_s7) <<< FRACTION_BITS;
		prod_s8[3] <= limb_sum(mpp_s7[2][0], mpp_s7[2][1], mpp_s7[2][2], mpp_s7[2][3]);
		prod_s8[4] <= limb_sum(mpp_s7[3][0], mpp_s7[3][1], mpp_s7[3][2], mpp_s7[3][3]);
		prod_s8[5] <= P_W'(numt_s7) <<< FRACTION_BITS;
	end

	assign dctl_in = '{valid: v_s8, zero: fail_s8};

	// one divider per output coordinate, all in lockstep
	for (genvar g = 0; g < 6; g++) begin : g_div
		lpcp_div u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl_i  (dctl_in),
			.num_i  (prod_s8[g]),
			.den_i  (den_s8),
			.pnt_i  (pnt_s8[g]),
			.ctl_o  (dctl[g]),
			.res_o  (res[g])
		);
	end

	assign done          = dctl[0].valid;
	assign parallel_fail = dctl[0].zero;
	assign near_first_x  = res[0];
	assign near_first_y  = res[1];
	assign near_first_z  = res[2];
	assign near_second_x = res[3];
	assign near_second_y = res[4];
	assign near_second_z = res[5];

`ifndef SYNTHESIS
	// every result strobe traces back to an accepted transaction
	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, PIPE_LAT))
		else $error("done without a matching start");

	// parallel lines give all-zero points
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && parallel_fail) |-> (near_first_x == 0 && near_first_y == 0 &&
		near_first_z == 0 && near_second_x == 0 && near_second_y == 0 &&
		near_second_z == 0))
		else $error("parallel result not zero");

	// dividers 0, 3 and 5 never drift apart
	a_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		dctl[0] == dctl[5] && dctl[0] == dctl[3])
		else $error("divider control out of step");
`endif

endmodule
